// ----- hdl/psd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the polyline source distributor.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int SPM_WIDTH  = 16;
  localparam logic [SPM_WIDTH-1:0] SPM_RESET = 16'd256;

  // source count fits 7 bits (at most 64), twice the count fits 8 bits
  localparam int N_WIDTH    = 7;
  localparam int DIV_WIDTH  = 8;

  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;

  // register index taken from paddr[2]
  localparam logic REG_SPM  = 1'b0;

endpackage

// ----- hdl/polyline_source_distributor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_source_distributor_unit
// Splits polyline segments into evenly spaced point sources.
// ----------------------------------------------------------------------------
// A vertex that starts a line, or the first one after reset, is stored. Any
// other vertex closes a segment and is worked through bit-serially:
// differences, sum of squares by shift-and-add, square root at one result
// bit a cycle, scaling by the density, count and two passes of three
// parallel serial dividers. Then the sources leave one per cycle while
// out_ready is high; the next vertex is taken after the last source.
module polyline_source_distributor_unit #(
  parameter int MAX_SOURCES_PER_SEGMENT = 64,
  parameter int COORD_WIDTH             = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psd_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [psd_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [psd_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       vertex_x,
  input  logic signed [COORD_WIDTH-1:0]       vertex_y,
  input  logic signed [COORD_WIDTH-1:0]       vertex_z,
  input  logic                                start_of_line,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       src_x,
  output logic signed [COORD_WIDTH-1:0]       src_y,
  output logic signed [COORD_WIDTH-1:0]       src_z,
  output logic                                last_of_segment,
  output logic                                count_saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int MW  = W + 1;
  localparam int SW  = 2 * W + 2;
  localparam int LW  = W + 1;
  localparam int SPW = psd_pkg::SPM_WIDTH;
  localparam int PW  = LW + SPW;
  localparam int QW  = W + 2;
  localparam int CW  = $clog2(SW + 1);
  localparam int NW  = psd_pkg::N_WIDTH;
  localparam int DVW = psd_pkg::DIV_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQUARE, S_SQRT, S_SCALE, S_COUNT, S_DIV0, S_DIV1, S_EMIT
  } state_t;

  state_t          state;
  logic [SPW-1:0]  spm;
  logic            have_prev;
  logic [W-1:0]    prev [3];
  logic [W-1:0]    cur  [3];
  logic [MW-1:0]   mag  [3];
  logic            neg  [3];
  logic [MW-1:0]   mag_d [3];
  logic            neg_d [3];
  logic [CW-1:0]   cnt;
  logic [1:0]      ax;
  logic [SW-1:0]   mcand;
  logic [MW-1:0]   mplier;
  logic [SW-1:0]   sumsq;
  logic [LW-1:0]   root;
  logic [LW:0]     rem;
  logic [LW+2:0]   sq_t;
  logic [LW+2:0]   sq_trial;
  logic            sq_ge;
  logic [LW-1:0]   root_next;
  logic [PW-1:0]   lenp;
  logic [PW-1:0]   pacc;
  logic [SPW-1:0]  sbits;
  logic [LW-1:0]   pq;
  logic [NW-1:0]   n;
  logic [NW-1:0]   k;
  logic            sat;
  logic            div_start;
  logic [DVW-1:0]  dsor;
  logic [QW-1:0]   dend [3];
  logic [QW-1:0]   dquo [3];
  logic [DVW-1:0]  drem [3];
  logic [2:0]      ddone;
  logic [QW-1:0]   qa [3];
  logic [DVW-1:0]  ra [3];
  logic [DVW-1:0]  rr [3];
  logic [W-1:0]    p  [3];
  logic [DVW-1:0]  rr_next [3];
  logic [W-1:0]    p_next  [3];
  logic            last;
  logic            cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == psd_pkg::REG_SPM) ?
                    {{(psd_pkg::DATA_WIDTH - SPW){1'b0}}, spm} : '0;
  assign in_ready = (state == S_IDLE);
  assign dsor     = {n, 1'b0};
  assign last     = (k == n - 1'b1);

  assign src_x           = p[0];
  assign src_y           = p[1];
  assign src_z           = p[2];
  assign last_of_segment = last;
  assign count_saturated = sat;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [MW-1:0] diff;
      diff     = {cur[a][W-1], cur[a]} - {prev[a][W-1], prev[a]};
      neg_d[a] = diff[MW-1];
      mag_d[a] = diff[MW-1] ? (~diff + 1'b1) : diff;
      dend[a]  = (state == S_DIV0) ? (QW'(mag[a]) + QW'(n)) : {mag[a], 1'b0};
    end
  end

  // square root: two radicand bits in, one root bit out per cycle
  assign sq_t      = {rem, sumsq[SW-1:SW-2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_ge     = sq_t >= sq_trial;
  assign root_next = {root[LW-2:0], sq_ge};

  assign pq = pacc[PW-1:SPW];

  // next source: running quotient and remainder by the per-step increment
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [DVW:0] rsum;
      logic         wrap;
      logic [W-1:0] inc;
      rsum       = {1'b0, rr[a]} + {1'b0, ra[a]};
      wrap       = rsum >= {1'b0, dsor};
      rr_next[a] = wrap ? DVW'(rsum - {1'b0, dsor}) : rsum[DVW-1:0];
      inc        = qa[a][W-1:0] + W'(wrap);
      p_next[a]  = neg[a] ? (p[a] - inc) : (p[a] + inc);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    psd_divider #(.DEND_WIDTH(QW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dend[a]),
      .divisor  (dsor),
      .quo      (dquo[a]),
      .rem      (drem[a]),
      .done     (ddone[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spm <= psd_pkg::SPM_RESET;
    end else if (cfg_wr && paddr[2] == psd_pkg::REG_SPM) begin
      spm <= pwdata[SPW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      for (int a = 0; a < 3; a++) prev[a] <= '0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (start_of_line || !have_prev) begin
              prev[0]   <= vertex_x;
              prev[1]   <= vertex_y;
              prev[2]   <= vertex_z;
              have_prev <= 1'b1;
            end else begin
              cur[0] <= vertex_x;
              cur[1] <= vertex_y;
              cur[2] <= vertex_z;
              state  <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          for (int a = 0; a < 3; a++) begin
            mag[a] <= mag_d[a];
            neg[a] <= neg_d[a];
          end
          mcand  <= SW'(mag_d[0]);
          mplier <= mag_d[0];
          sumsq  <= '0;
          cnt    <= CW'(MW);
          ax     <= 2'd0;
          state  <= S_SQUARE;
        end
        S_SQUARE: begin
          if (mplier[0]) sumsq <= sumsq + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            if (ax == 2'd2) begin
              root  <= '0;
              rem   <= '0;
              cnt   <= CW'(LW);
              state <= S_SQRT;
            end else begin
              ax     <= ax + 1'b1;
              mcand  <= SW'(mag[ax + 1'b1]);
              mplier <= mag[ax + 1'b1];
              cnt    <= CW'(MW);
            end
          end
        end
        S_SQRT: begin
          root  <= root_next;
          rem   <= sq_ge ? (LW+1)'(sq_t - sq_trial) : sq_t[LW:0];
          sumsq <= sumsq << 2;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            lenp  <= PW'(root_next);
            pacc  <= '0;
            sbits <= spm;
            cnt   <= CW'(SPW);
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (sbits[0]) pacc <= pacc + lenp;
          lenp  <= lenp << 1;
          sbits <= sbits >> 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= S_COUNT;
        end
        S_COUNT: begin
          if (pq > LW'(MAX_SOURCES_PER_SEGMENT)) begin
            n   <= NW'(MAX_SOURCES_PER_SEGMENT);
            sat <= 1'b1;
          end else begin
            n   <= (pq == '0) ? NW'(1) : NW'(pq);
            sat <= 1'b0;
          end
          div_start <= 1'b1;
          state     <= S_DIV0;
        end
        S_DIV0: begin
          if (&ddone) begin
            for (int a = 0; a < 3; a++) begin
              p[a]  <= neg[a] ? (prev[a] - dquo[a][W-1:0]) : (prev[a] + dquo[a][W-1:0]);
              rr[a] <= drem[a];
            end
            div_start <= 1'b1;
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (&ddone) begin
            for (int a = 0; a < 3; a++) begin
              qa[a] <= dquo[a];
              ra[a] <= drem[a];
            end
            k         <= '0;
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              for (int a = 0; a < 3; a++) prev[a] <= cur[a];
              state <= S_IDLE;
            end else begin
              for (int a = 0; a < 3; a++) begin
                p[a]  <= p_next[a];
                rr[a] <= rr_next[a];
              end
              k <= k + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("vertex request taken while sources pending");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (k < n))
    else $error("source index beyond segment count");

  a_sat_means_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count_saturated) |-> (n == NW'(MAX_SOURCES_PER_SEGMENT)))
    else $error("saturation flag without clipped count");

  a_last_ends_segment: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_segment) |=> !out_valid)
    else $error("source request after last of segment");

endmodule

// ----- hdl/psd_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_divider
// Bit-serial restoring divider: one quotient bit per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module psd_divider #(
  parameter int DEND_WIDTH = 34
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [DEND_WIDTH-1:0]            dividend,
  input  logic [psd_pkg::DIV_WIDTH-1:0]    divisor,
  output logic [DEND_WIDTH-1:0]            quo,
  output logic [psd_pkg::DIV_WIDTH-1:0]    rem,
  output logic                             done
);

  localparam int DVW = psd_pkg::DIV_WIDTH;
  localparam int CW  = $clog2(DEND_WIDTH + 1);

  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DVW:0]   trial;
  logic           ge;

  // next partial remainder takes the top dividend bit
  assign trial = {rem, quo[DEND_WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DEND_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DEND_WIDTH-2:0], ge};
      rem <= ge ? DVW'(trial - {1'b0, divisor}) : trial[DVW-1:0];
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polyline source distributor: vertex requests go
// in, a local source-placement model works out each segment's sources, and
// every emitted source is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW      = 32;
  localparam int MAX_SRC = 64;
  localparam int SETTLE  = 300;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [CW-1:0] x, y, z;
    logic          last, sat;
  } source_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [psd_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [psd_pkg::DATA_WIDTH-1:0] pwdata = '0;
  logic [psd_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic signed [CW-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic start_of_line = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic signed [CW-1:0] src_x, src_y, src_z;
  logic last_of_segment, count_saturated;

  polyline_source_distributor_unit #(
    .MAX_SOURCES_PER_SEGMENT(MAX_SRC),
    .COORD_WIDTH(CW)
  ) dut (.*);

  // local copy of block state
  logic [psd_pkg::SPM_WIDTH-1:0] density = psd_pkg::SPM_RESET;
  logic [CW-1:0] last_x = '0, last_y = '0, last_z = '0;
  bit have_vertex = 0;

  source_t pending_sources[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int hold_cycles = 0;
  int errors = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CW-1:0] place_axis(logic [CW-1:0] start, longint d,
                                               longint k, longint n);
    logic [63:0] mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag * (2 * k + 1) + n) / (2 * n);
    return (d < 0) ? start - q[CW-1:0] : start + q[CW-1:0];
  endfunction

  function automatic void predict_sources(logic [CW-1:0] vx, vy, vz, logic sol);
    longint dx, dy, dz, n;
    logic [127:0] sum_sq;
    logic [63:0] seg_len, trial, scaled;
    bit sat;
    source_t s;
    if (sol || !have_vertex) begin
      last_x = vx; last_y = vy; last_z = vz;
      have_vertex = 1;
      return;
    end
    dx = longint'($signed(vx)) - longint'($signed(last_x));
    dy = longint'($signed(vy)) - longint'($signed(last_y));
    dz = longint'($signed(vz)) - longint'($signed(last_z));
    sum_sq = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
           + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy)
           + 128'(dz < 0 ? -dz : dz) * 128'(dz < 0 ? -dz : dz);
    seg_len = '0;
    for (int b = 50; b >= 0; b--) begin
      trial = seg_len | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sum_sq) seg_len = trial;
    end
    scaled = seg_len * 64'(density);
    sat = (scaled >> 16) > MAX_SRC;
    n = sat ? MAX_SRC : longint'(scaled >> 16);
    if (n == 0) n = 1;
    for (longint k = 0; k < n; k++) begin
      s.x = place_axis(last_x, dx, k, n);
      s.y = place_axis(last_y, dy, k, n);
      s.z = place_axis(last_z, dz, k, n);
      s.last = (k + 1 == n);
      s.sat = sat;
      pending_sources.insert(pending_sources.size(), s);
    end
    last_x = vx; last_y = vy; last_z = vz;
  endfunction

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: begin
          out_ready <= ($urandom_range(99) >= 76);
        end
        IDLE_BOTH: begin
          out_ready <= ($urandom_range(99) >= 13);
        end
        default: begin
          out_ready <= 1'b1;
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    source_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_sources.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected source x=%h y=%h z=%h", src_x, src_y, src_z);
      end else begin
        e = pending_sources.pop_front();
        if (src_x !== e.x || src_y !== e.y || src_z !== e.z ||
            last_of_segment !== e.last || count_saturated !== e.sat) begin
          errors++;
          if (errors <= 10)
            $display("source exp %h %h %h l%b s%b got %h %h %h l%b s%b",
                     e.x, e.y, e.z, e.last, e.sat,
                     src_x, src_y, src_z, last_of_segment, count_saturated);
        end
      end
    end
  end

  task automatic send_vertex(logic [CW-1:0] vx, vy, vz, logic sol);
    int gap, p;
    gap = 0;
    p = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    while ($urandom_range(99) < p) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= vx;
    vertex_y <= vy;
    vertex_z <= vz;
    start_of_line <= sol;
    do @(posedge clk); while (!in_ready);
    predict_sources(vx, vy, vz, sol);
  endtask

  // wait for every source, then for any work on a vertex with no sources
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sources.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [psd_pkg::ADDR_WIDTH-1:0] addr,
                           logic [psd_pkg::DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == psd_pkg::REG_SPM) density = data[psd_pkg::SPM_WIDTH-1:0];
  endtask

  // random polyline: start vertex then segments of mostly moderate length
  task automatic send_polylines(int items);
    logic [CW-1:0] px, py, pz;
    int step;
    for (int i = 0; i < items; i++) begin
      if (i == 0 || $urandom_range(9) == 0) begin
        px = $urandom; py = $urandom; pz = $urandom;
        if ($urandom_range(1)) begin
          px = px >>> 8; py = py >>> 8; pz = pz >>> 8;
        end
        send_vertex(px, py, pz, 1'b1);
      end else begin
        case ($urandom_range(9))
          0: begin
            px = $urandom; py = $urandom; pz = $urandom;
          end
          1: begin
            step = 0;
          end
          default: begin
            step = $urandom_range(12000);
            px += $urandom_range(2 * step) - step;
            py += $urandom_range(2 * step) - step;
            pz += $urandom_range(2 * step) - step;
          end
        endcase
        send_vertex(px, py, pz, 1'b0);
      end
    end
  endtask

  task automatic test_directed();
    idle_mode = IDLE_NONE;
    send_vertex(32'sd1000, 32'sd2000, 32'sd3000, 1'b0);  // no previous vertex
    send_vertex(32'sd1000, 32'sd2000, 32'sd3000, 1'b0);  // zero length
    send_vertex(32'sd1000 + 16384, 32'sd2000, 32'sd3000, 1'b0);  // exactly max
    send_vertex(32'sd1000 + 16384 + 16640, 32'sd2000, 32'sd3000, 1'b0);  // one over
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    send_vertex(-32'sd700, 32'sd333, -32'sd5, 1'b0);
    send_vertex(32'hffffffff, 32'h00000001, 32'h55555555, 1'b1);
    send_vertex(32'haaaaaaaa, 32'hfffffffe, 32'h00000100, 1'b0);
    drain();
    write_reg(3'd4, 32'd9);  // no such register
    write_reg(3'd0, 32'd1);  // tiny density
    send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_vertex(32'sd4000000, -32'sd9000000, 32'sd1, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h0, 1'b0);
    drain();
    write_reg(3'd0, 32'hffff);
    send_vertex(32'sd10, 32'sd20, 32'sd30, 1'b1);
    send_vertex(32'sd73, -32'sd20, 32'sd31, 1'b0);
    send_vertex(32'sd73, -32'sd20, 32'sd31, 1'b0);
    drain();
  endtask

  task automatic test_density_phases();
    logic [psd_pkg::DATA_WIDTH-1:0] setting[4] = '{32'd256, 32'd1, 32'hffff, 32'd0};
    for (int ph = 0; ph < 4; ph++) begin
      setting[3] = $urandom_range(2, 4000);
      for (int m = 0; m < 4; m++) begin
        write_reg(3'd0, (ph == 3 && m == 3) ? 32'd256 : setting[ph]);
        idle_mode = idle_mode_t'(m);
        send_polylines(22);
        drain();
      end
    end
  endtask

  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    write_reg(3'd0, 32'd512);
    hold_cycles = 3000;
    send_polylines(50);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_density_phases();
    test_backpressure();
    if (errors == 0 && pending_sources.size() == 0) begin
      $display("polyline_source_distributor_unit: match");
    end else begin
      $display("polyline_source_distributor_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("polyline_source_distributor_unit: mismatch");
    $finish;
  end

endmodule
